// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge.
`define GLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/glr_pkg.sv =====
// ----------------------------------------------------------------------------
// glr_pkg
// Types, constants and the glyph palette for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

  localparam int unsigned MAX_DIM_DEF = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned COORD_W = 6;
  localparam int unsigned INTEN_W = 9;
  localparam int unsigned WIN_W   = 7;
  localparam int unsigned BIDX_W  = 13;
  localparam int unsigned GLYPH_W = 7;
  localparam int unsigned CFG_IDX_W = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 4'd1;

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

  // One classified line request.
  typedef struct packed {
    logic               xmajor;  // x is the stepping axis
    logic               down;    // first endpoint is the higher one
    logic               neg;     // minor delta negative
    logic               qi;      // whole part of the per-step increment
    logic [COORD_W-1:0] lo;      // lowest major coordinate
    logic [COORD_W-1:0] m0;      // minor coordinate of first endpoint
    logic [COORD_W-1:0] len;     // major length
    logic [COORD_W-1:0] q0;      // initial minor offset magnitude
    logic [WIN_W-1:0]   r0;      // initial remainder
    logic [WIN_W-1:0]   ri;      // fractional part of the increment
    logic [WIN_W-1:0]   two_l;   // divisor 2*len
    logic [GLYPH_W-1:0] glyph;
  } setup_t;

  // Palette "@#W$9876543210?!abc;:+=-,._ " by index.
  function automatic logic [GLYPH_W-1:0] glyph_code(input logic [4:0] idx);
    logic [GLYPH_W-1:0] c;
    case (idx)
      5'd0:  c = 7'h40;
      5'd1:  c = 7'h23;
      5'd2:  c = 7'h57;
      5'd3:  c = 7'h24;
      5'd4:  c = 7'h39;
      5'd5:  c = 7'h38;
      5'd6:  c = 7'h37;
      5'd7:  c = 7'h36;
      5'd8:  c = 7'h35;
      5'd9:  c = 7'h34;
      5'd10: c = 7'h33;
      5'd11: c = 7'h32;
      5'd12: c = 7'h31;
      5'd13: c = 7'h30;
      5'd14: c = 7'h3F;
      5'd15: c = 7'h21;
      5'd16: c = 7'h61;
      5'd17: c = 7'h62;
      5'd18: c = 7'h63;
      5'd19: c = 7'h3B;
      5'd20: c = 7'h3A;
      5'd21: c = 7'h2B;
      5'd22: c = 7'h3D;
      5'd23: c = 7'h2D;
      5'd24: c = 7'h2C;
      5'd25: c = 7'h2E;
      5'd26: c = 7'h5F;
      default: c = 7'h20;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/glyph_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_line_rasterizer_unit
// Line rasterizer: one request in, one point per major-axis step out.
// ----------------------------------------------------------------------------
// A request moves from the queue into the stepper when it is idle; each
//   point leaves through the output register. A line of N points
//   (N = min(len+1, MAX_DIM)) takes the stepper for loading, then one
//   point per cycle while the output is not stalled. The stepper is the
//   limit; a 2-deep queue lets requests arrive while a line is drawn.
// Reset (rst_ni low, async): queue and stepper empty, window 64 x 64.
`default_nettype none

module glyph_line_rasterizer_unit #(
  parameter int unsigned MAX_DIM = glr_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [glr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [glr_pkg::WIN_W-1:0]         cfg_data_i,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [5:0] x_start, [11:6] y_start, [17:12] x_end, [23:18] y_end,
  // [32:24] intensity, [39:33] zero
  input  wire logic [glr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // point stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [5:0] pixel_x, [11:6] pixel_y, [24:12] buffer_index, [31:25] glyph
  output logic [glr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [0] visible
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  localparam int unsigned CW = glr_pkg::COORD_W;

  // Window registers; always writable, indexes past the list are dropped.
  logic [glr_pkg::WIN_W-1:0] width_q, width_d, height_q, height_d;

  glr_pkg::setup_t front_setup, q_data;
  logic            q_full, q_valid, q_pop;
  logic            s_fire;

  logic [CW-1:0]                 pixel_x, pixel_y;
  logic [glr_pkg::BIDX_W-1:0]    buffer_index;
  logic [glr_pkg::GLYPH_W-1:0]   glyph;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        glr_pkg::CFG_IDX_WIDTH:  width_d  = cfg_data_i;
        glr_pkg::CFG_IDX_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= glr_pkg::WIN_RESET;
      height_q <= glr_pkg::WIN_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Front: classify the incoming request combinationally, push into queue.
  glr_front u_front (
    .x_start_i   (s_axis_tdata[5:0]),
    .y_start_i   (s_axis_tdata[11:6]),
    .x_end_i     (s_axis_tdata[17:12]),
    .y_end_i     (s_axis_tdata[23:18]),
    .intensity_i (s_axis_tdata[32:24]),
    .setup_o     (front_setup)
  );

  assign s_axis_tready = !q_full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  glr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_fire),
    .data_i  (front_setup),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // Back: incremental stepper plus registered output.
  glr_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_width_i    (width_q),
    .win_height_i   (height_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .buffer_index_o (buffer_index),
    .glyph_o        (glyph),
    .visible_o      (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {glyph, buffer_index, pixel_y, pixel_x};

endmodule

`default_nettype wire

// ===== hw/rtl/glr_front.sv =====
// ----------------------------------------------------------------------------
// glr_front
// Classifies a line request: axis, direction, increments and glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_front (
  input  wire logic [glr_pkg::COORD_W-1:0] x_start_i,
  input  wire logic [glr_pkg::COORD_W-1:0] y_start_i,
  input  wire logic [glr_pkg::COORD_W-1:0] x_end_i,
  input  wire logic [glr_pkg::COORD_W-1:0] y_end_i,
  input  wire logic [glr_pkg::INTEN_W-1:0] intensity_i,
  output glr_pkg::setup_t                  setup_o
);

  logic [glr_pkg::COORD_W-1:0] adx, ady, s0, e0, m0, admin, len;
  logic                        neg_x, neg_y, xmajor, down, qi;
  logic [13:0]                 gsum;
  logic [4:0]                  gidx;

  always_comb begin
    neg_x  = x_end_i < x_start_i;
    neg_y  = y_end_i < y_start_i;
    adx    = neg_x ? x_start_i - x_end_i : x_end_i - x_start_i;
    ady    = neg_y ? y_start_i - y_end_i : y_end_i - y_start_i;
    xmajor = adx > ady;
    s0     = xmajor ? x_start_i : y_start_i;
    e0     = xmajor ? x_end_i : y_end_i;
    m0     = xmajor ? y_start_i : x_start_i;
    len    = xmajor ? adx : ady;
    admin  = xmajor ? ady : adx;
    down   = s0 > e0;
    qi     = (admin == len) && (len != '0);

    // index = round((256 - v) * 27 / 256), ties up; v >= 256 gives 0
    gsum = 14'(({5'd0, 9'd256 - intensity_i}) * 14'd54) + 14'd256;
    gidx = intensity_i[8] ? 5'd0 : gsum[13:9];

    setup_o.xmajor = xmajor;
    setup_o.down   = down;
    setup_o.neg    = xmajor ? neg_y : neg_x;
    setup_o.qi     = qi;
    setup_o.lo     = down ? e0 : s0;
    setup_o.m0     = m0;
    setup_o.len    = len;
    setup_o.q0     = down ? admin : '0;
    setup_o.r0     = {1'b0, len};
    setup_o.ri     = qi ? '0 : {admin, 1'b0};
    setup_o.two_l  = {len, 1'b0};
    setup_o.glyph  = glr_pkg::glyph_code(gidx);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glr_queue.sv =====
// ----------------------------------------------------------------------------
// glr_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  glr_pkg::setup_t      data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output glr_pkg::setup_t      data_o
);

  localparam int unsigned Depth = glr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  glr_pkg::setup_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glr_back.sv =====
// ----------------------------------------------------------------------------
// glr_back
// Steps along the major axis into an output register, one point per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module glr_back #(
  parameter int unsigned MAX_DIM = glr_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [glr_pkg::WIN_W-1:0]     win_width_i,
  input  wire logic [glr_pkg::WIN_W-1:0]     win_height_i,
  input  wire logic                          q_valid_i,
  input  glr_pkg::setup_t                    q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [glr_pkg::COORD_W-1:0]        pixel_x_o,
  output logic [glr_pkg::COORD_W-1:0]        pixel_y_o,
  output logic [glr_pkg::BIDX_W-1:0]         buffer_index_o,
  output logic [glr_pkg::GLYPH_W-1:0]        glyph_o,
  output logic                               visible_o,
  output logic                               last_o
);

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned CW   = glr_pkg::COORD_W;
  localparam int unsigned WW   = glr_pkg::WIN_W;

  glr_pkg::setup_t cur_q;
  logic            active_q, active_d;
  logic [CntW-1:0] j_q, j_d, last_j_q, last_j_d;
  logic [CW-1:0]   q_q, q_d;
  logic [WW-1:0]   r_q, r_d;

  logic            out_free, step, last_pt;
  logic [CW-1:0]   major, minor, px, py;
  logic [WW:0]     rsum;
  logic [WW:0]     rdiff;
  logic [WW:0]     w_plus;
  logic [14:0]     prod;

  logic            vld_q;
  logic [CW-1:0]   px_q, py_q;
  logic [glr_pkg::BIDX_W-1:0]  bidx_q;
  logic [glr_pkg::GLYPH_W-1:0] glyph_q;
  logic            vis_q, last_q;

  assign out_free = !vld_q || out_ready_i;
  assign step     = active_q && out_free;
  assign q_pop_o  = !active_q && q_valid_i;
  assign last_pt  = j_q == last_j_q;

  // current point
  always_comb begin
    major  = cur_q.lo + CW'(j_q);
    minor  = cur_q.neg ? cur_q.m0 - q_q : cur_q.m0 + q_q;
    px     = cur_q.xmajor ? major : minor;
    py     = cur_q.xmajor ? minor : major;
    w_plus = {1'b0, win_width_i} + 1'b1;
    prod   = 15'(py * w_plus) + 15'(px);
  end

  // stepper: exact running quotient/remainder of (2*|dmin|*u + len) / (2*len)
  always_comb begin
    active_d = active_q;
    j_d      = j_q;
    last_j_d = last_j_q;
    q_d      = q_q;
    r_d      = r_q;
    rsum     = {1'b0, r_q} + {1'b0, cur_q.ri};
    rdiff    = {1'b0, r_q} + {1'b0, cur_q.two_l} - {1'b0, cur_q.ri};
    if (q_pop_o) begin
      active_d = 1'b1;
      j_d      = '0;
      q_d      = q_data_i.q0;
      r_d      = q_data_i.r0;
      last_j_d = ({1'b0, q_data_i.len} >= WW'(MAX_DIM - 1)) ? CntW'(MAX_DIM - 1)
                                                             : q_data_i.len[CntW-1:0];
    end else if (step) begin
      if (last_pt) begin
        active_d = 1'b0;
      end else begin
        j_d = j_q + 1'b1;
        if (!cur_q.down) begin
          if (rsum >= {1'b0, cur_q.two_l}) begin
            r_d = WW'(rsum - {1'b0, cur_q.two_l});
            q_d = q_q + CW'(cur_q.qi) + 1'b1;
          end else begin
            r_d = rsum[WW-1:0];
            q_d = q_q + CW'(cur_q.qi);
          end
        end else begin
          if (r_q < cur_q.ri) begin
            r_d = rdiff[WW-1:0];
            q_d = q_q - CW'(cur_q.qi) - 1'b1;
          end else begin
            r_d = r_q - cur_q.ri;
            q_d = q_q - CW'(cur_q.qi);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      if (out_free) begin
        vld_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    last_j_q <= last_j_d;
    q_q      <= q_d;
    r_q      <= r_d;
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
    if (step) begin
      px_q    <= px;
      py_q    <= py;
      bidx_q  <= prod[glr_pkg::BIDX_W-1:0];
      glyph_q <= cur_q.glyph;
      vis_q   <= ({1'b0, px} < win_width_i) && ({1'b0, py} < win_height_i);
      last_q  <= last_pt;
    end
  end

  assign out_valid_o    = vld_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign buffer_index_o = bidx_q;
  assign glyph_o        = glyph_q;
  assign visible_o      = vis_q;
  assign last_o         = last_q;

  `GLR_ASSERT(a_j_in_range, !active_q || (j_q <= last_j_q), "step counter past end")
  `GLR_ASSERT(a_rem_bounded, !active_q || (r_q < cur_q.two_l) || (cur_q.two_l == '0),
              "remainder out of range")
  `GLR_ASSERT_NEXT(a_last_ends, step && last_pt, !active_q && vld_q && last_o,
                   "line did not end on last point")

endmodule

`default_nettype wire

// ===== verif/glyph_line_rasterizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_line_rasterizer_unit_tb
// Drives line requests and window settings into the rasterizer, predicts
// every point (coordinates, buffer address, glyph, clip flag, end marker)
// and checks the point stream in order, under random source and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_line_rasterizer_unit_tb;

  import glr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned FULL_SCALE  = 256;  // intensity of 1.0
  localparam int unsigned SHADE_LAST  = 27;   // last palette entry
  localparam int unsigned COORD_MAX   = 63;
  localparam int unsigned PHASE_LINES = 40;

  // Palette, darkest-looking glyph first; entry i sits at bits 8*(27-i).
  localparam logic [8*28-1:0] SHADE_CHARS = "@#W$9876543210?!abc;:+=-,._ ";

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [BIDX_W-1:0]  addr;
    logic [GLYPH_W-1:0] glyph;
    logic               vis;
    logic               last;
  } point_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [WIN_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // Points still owed by the block, oldest first.
  point_t points_due[$];

  // Shadow of the window registers.
  logic [WIN_W-1:0] win_cols;
  logic [WIN_W-1:0] win_rows;

  bit          src_gaps;
  bit          sink_stalls;
  int unsigned sink_wait;
  int unsigned cycle_count;
  int unsigned mismatches;

  glyph_line_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // num/den to nearest, ties away from zero.
  function automatic int round_ratio(input int num, input int den);
    int an;
    int ad;
    int q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // Glyph for index round((1 - v) * 27); anything at or above 1.0 is '@'.
  function automatic logic [GLYPH_W-1:0] shade_code(input logic [INTEN_W-1:0] inten);
    int unsigned idx;
    if (inten >= FULL_SCALE) idx = 0;
    else idx = ((FULL_SCALE - inten) * SHADE_LAST * 2 + FULL_SCALE) / (2 * FULL_SCALE);
    if (idx > SHADE_LAST) idx = SHADE_LAST;
    return SHADE_CHARS[8 * (SHADE_LAST - idx) +: GLYPH_W];
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Queues every point of one line in step order.
  function automatic void predict_line(input logic [COORD_W-1:0] xa, ya, xb, yb,
                                       input logic [INTEN_W-1:0] inten);
    int     dx, dy, adx, ady;
    int     s0, e0, m0, dmaj, dmin, lo, hi, n, k, m, x, y, addr;
    bit     xmaj;
    point_t p;
    dx   = int'(xb) - int'(xa);
    dy   = int'(yb) - int'(ya);
    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy < 0) ? -dy : dy;
    xmaj = adx > ady;  // a 45 degree line steps along y
    s0   = xmaj ? xa : ya;
    e0   = xmaj ? xb : yb;
    m0   = xmaj ? ya : xa;
    dmaj = xmaj ? dx : dy;
    dmin = xmaj ? dy : dx;
    lo   = (s0 < e0) ? s0 : e0;
    hi   = (s0 < e0) ? e0 : s0;
    n    = hi - lo + 1;
    if (n > MAX_DIM_DEF) n = MAX_DIM_DEF;
    for (int i = 0; i < n; i++) begin
      k = lo + i;
      // Zero-length line: no division, single point at the endpoint.
      m = (dmaj == 0) ? m0 : m0 + round_ratio(dmin * (k - s0), dmaj);
      x = xmaj ? k : m;
      y = xmaj ? m : k;
      p.px    = x[COORD_W-1:0];
      p.py    = y[COORD_W-1:0];
      addr    = int'(p.py) * (int'(win_cols) + 1) + int'(p.px);
      p.addr  = addr[BIDX_W-1:0];
      p.glyph = shade_code(inten);
      p.vis   = (p.px < win_cols) && (p.py < win_rows);
      p.last  = (i == n - 1);
      points_due.push_back(p);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sink side: per-item random ready stall, and the point checker
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (m_axis_tready && m_axis_tvalid) begin
      sink_wait = sink_stalls ? $urandom_range(0, 3) : 0;
      m_axis_tready <= (sink_wait == 0);
    end else if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= (sink_wait == 0);
    end
  end

  always @(posedge clk_i) begin : check_points
    point_t got;
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px    = m_axis_tdata[5:0];
      got.py    = m_axis_tdata[11:6];
      got.addr  = m_axis_tdata[24:12];
      got.glyph = m_axis_tdata[31:25];
      got.vis   = m_axis_tuser;
      got.last  = m_axis_tlast;
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected point: x=%0d y=%0d addr=%0d glyph=%h vis=%b last=%b",
                   got.px, got.py, got.addr, got.glyph, got.vis, got.last);
      end else begin
        want = points_due.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.addr !== want.addr ||
            got.glyph !== want.glyph || got.vis !== want.vis || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("point mismatch: exp x=%0d y=%0d addr=%0d glyph=%h vis=%b last=%b, %s",
                     want.px, want.py, want.addr, want.glyph, want.vis, want.last,
                     $sformatf("got x=%0d y=%0d addr=%0d glyph=%h vis=%b last=%b",
                               got.px, got.py, got.addr, got.glyph, got.vis, got.last));
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("glyph_line_rasterizer_unit_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // One line request; valid stays up afterwards so back-to-back items flow.
  task automatic send_line(input logic [COORD_W-1:0] xa, ya, xb, yb,
                           input logic [INTEN_W-1:0] inten);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({inten, yb, xb, ya, xa});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_line(xa, ya, xb, yb, inten);
  endtask

  // Mostly short or uniform lines, a few single points; intensity now and
  // then well above full scale.
  task automatic send_random_line();
    logic [COORD_W-1:0] xa, ya, xb, yb;
    logic [INTEN_W-1:0] inten;
    int unsigned        shape;
    xa    = $urandom;
    ya    = $urandom;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      xb = xa;
      yb = ya;
    end else if (shape <= 3) begin
      xb = clip_coord(int'(xa) + int'($urandom_range(0, 8)) - 4);
      yb = clip_coord(int'(ya) + int'($urandom_range(0, 8)) - 4);
    end else begin
      xb = $urandom;
      yb = $urandom;
    end
    if ($urandom_range(0, 3) == 0) inten = $urandom;
    else inten = $urandom_range(0, FULL_SCALE);
    send_line(xa, ya, xb, yb, inten);
  endtask

  // Drop valid and hold off until every owed point has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk_i);
  endtask

  // Writes width, then height; optionally a write to an unused index between.
  task automatic set_window(input logic [WIN_W-1:0] cols, rows, input bit stray);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [WIN_W-1:0]     data[3];
    int                   n;
    idx[0]  = CFG_IDX_WIDTH;
    data[0] = cols;
    n       = 1;
    if (stray) begin
      idx[1]  = $urandom_range(int'(CFG_IDX_HEIGHT) + 1, int'(CFG_IDX_TOP));
      data[1] = $urandom;
      n       = 2;
    end
    idx[n]  = CFG_IDX_HEIGHT;
    data[n] = rows;
    n++;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        CFG_IDX_WIDTH:  win_cols = data[i];
        CFG_IDX_HEIGHT: win_rows = data[i];
        default: ;  // unused index, no effect
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset window 64 x 64: extreme endpoints, every octant but x-major with x
  // falling and y rising, rounding ties, glyph boundaries.
  task automatic test_directed_lines();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_line(0, 0, 0, 0, 0);            // single point, last palette index
    send_line(63, 63, 63, 63, 256);      // single point, full scale
    send_line(0, 0, 63, 63, 128);        // diagonal, halfway glyph index
    send_line(63, 0, 0, 63, 255);        // anti-diagonal, steps run backward
    send_line(0, 7, 63, 7, 257);         // horizontal, just above full scale
    send_line(40, 63, 40, 0, 511);       // vertical, top to bottom
    send_line(0, 0, 4, 2, 1);            // minor ties at odd steps
    send_line(4, 2, 0, 0, 2);            // same ties, negative offsets
    send_line(0, 2, 4, 0, 9);            // minor axis falling
    send_line(10, 10, 13, 11, 64);       // shallow x-major
    send_line(5, 60, 6, 3, 192);         // steep y-major
    send_line(63, 63, 0, 0, 10);         // full diagonal, reversed
    send_line(31, 32, 32, 31, 5);        // two-step tie on both axes
    send_line(20, 20, 20, 20, 14);       // single points sweeping glyphs
    send_line(21, 20, 21, 20, 137);
    send_line(22, 20, 22, 20, 246);
    send_line(0, 63, 63, 62, 383);       // nearly flat, full length
  endtask

  // Window registers at their extremes and in between, with clipping lines
  // aimed across each window edge and stray writes to unused indexes.
  task automatic test_window_sizes();
    logic [WIN_W-1:0] cols[6];
    logic [WIN_W-1:0] rows[6];
    cols[0] = 1;   rows[0] = 1;
    cols[1] = 0;   rows[1] = 0;          // nothing visible
    cols[2] = 127; rows[2] = 127;        // widest address stride
    cols[3] = 64;  rows[3] = 1;
    cols[4] = 1;   rows[4] = 64;
    cols[5] = 33;  rows[5] = 17;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      set_window(cols[ph], rows[ph], ph[0]);
      src_gaps    = $urandom_range(0, 1);
      sink_stalls = $urandom_range(0, 1);
      send_line(clip_coord(int'(cols[ph]) - 2), clip_coord(int'(rows[ph]) - 2),
                clip_coord(int'(cols[ph]) + 1), clip_coord(int'(rows[ph]) + 1),
                $urandom_range(0, FULL_SCALE));
      repeat (4) send_random_line();
    end
  endtask

  // Bulk random lines: each phase has its own window and idle pattern,
  // including one stretch with no idling and one mid-phase drain.
  task automatic test_random_lines();
    logic [WIN_W-1:0] cols;
    logic [WIN_W-1:0] rows;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      set_window(cols, rows, $urandom_range(0, 1));
      src_gaps    = ph[0];
      sink_stalls = ph[1];
      for (int i = 0; i < PHASE_LINES; i++) begin
        // Source holds off until the block is empty, then resumes.
        if (ph == 3 && i == PHASE_LINES / 2) settle();
        send_random_line();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sink_wait     = 1;
    src_gaps      = 1'b0;
    sink_stalls   = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    win_cols      = WIN_RESET;
    win_rows      = WIN_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_window_sizes();
    test_random_lines();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("glyph_line_rasterizer_unit_tb: done, clean");
    end else begin
      $display("glyph_line_rasterizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
